### hdl/mue_pkg.sv
// Shared types, constants and the Morse pattern table for the unit encoder.
package mue_pkg;

  localparam int PAT_W     = 19;               // longest element pattern (digit zero)
  localparam int GAP_UNITS = 3;                // off units after every character
  localparam int UNIT_W    = PAT_W + GAP_UNITS;
  localparam int CNT_W     = $clog2(UNIT_W + 1);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Element pattern right-aligned in bits, first unit in the highest used bit.
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [PAT_W-1:0] bits;
  } pat_t;

  // Full unit sequence for one character: pattern then gap, sent from bit total-1 down.
  typedef struct packed {
    logic [CNT_W-1:0]  total;
    logic [UNIT_W-1:0] units;
  } seq_t;

  function automatic pat_t mk_pat(input logic [CNT_W-1:0] len, input logic [PAT_W-1:0] bits);
    pat_t p;
    p.len  = len;
    p.bits = bits;
    return p;
  endfunction

  function automatic pat_t letter_pattern(input logic [4:0] idx);
    pat_t p;
    case (idx)
      5'd0:    p = mk_pat(5'd5,  19'b10111);
      5'd1:    p = mk_pat(5'd9,  19'b111010101);
      5'd2:    p = mk_pat(5'd11, 19'b11101011101);
      5'd3:    p = mk_pat(5'd7,  19'b1110101);
      5'd4:    p = mk_pat(5'd1,  19'b1);
      5'd5:    p = mk_pat(5'd9,  19'b101011101);
      5'd6:    p = mk_pat(5'd9,  19'b111011101);
      5'd7:    p = mk_pat(5'd7,  19'b1010101);
      5'd8:    p = mk_pat(5'd3,  19'b101);
      5'd9:    p = mk_pat(5'd13, 19'b1011101110111);
      5'd10:   p = mk_pat(5'd9,  19'b111010111);
      5'd11:   p = mk_pat(5'd9,  19'b101110101);
      5'd12:   p = mk_pat(5'd7,  19'b1110111);
      5'd13:   p = mk_pat(5'd5,  19'b11101);
      5'd14:   p = mk_pat(5'd11, 19'b11101110111);
      5'd15:   p = mk_pat(5'd11, 19'b10111011101);
      5'd16:   p = mk_pat(5'd13, 19'b1110111010111);
      5'd17:   p = mk_pat(5'd7,  19'b1011101);
      5'd18:   p = mk_pat(5'd5,  19'b10101);
      5'd19:   p = mk_pat(5'd3,  19'b111);
      5'd20:   p = mk_pat(5'd7,  19'b1010111);
      5'd21:   p = mk_pat(5'd9,  19'b101010111);
      5'd22:   p = mk_pat(5'd9,  19'b101110111);
      5'd23:   p = mk_pat(5'd11, 19'b11101010111);
      5'd24:   p = mk_pat(5'd13, 19'b1110101110111);
      5'd25:   p = mk_pat(5'd11, 19'b11101110101);
      default: p = mk_pat(5'd0,  19'b0);
    endcase
    return p;
  endfunction

  function automatic pat_t digit_pattern(input logic [3:0] idx);
    pat_t p;
    case (idx)
      4'd0:    p = mk_pat(5'd19, 19'b1110111011101110111);
      4'd1:    p = mk_pat(5'd17, 19'b10111011101110111);
      4'd2:    p = mk_pat(5'd15, 19'b101011101110111);
      4'd3:    p = mk_pat(5'd13, 19'b1010101110111);
      4'd4:    p = mk_pat(5'd11, 19'b10101010111);
      4'd5:    p = mk_pat(5'd9,  19'b101010101);
      4'd6:    p = mk_pat(5'd11, 19'b11101010101);
      4'd7:    p = mk_pat(5'd13, 19'b1110111010101);
      4'd8:    p = mk_pat(5'd15, 19'b111011101110101);
      4'd9:    p = mk_pat(5'd17, 19'b11101110111011101);
      default: p = mk_pat(5'd0,  19'b0);
    endcase
    return p;
  endfunction

endpackage

### hdl/mue_lookup.sv
// Character classification and pattern lookup, giving the full unit sequence.
module mue_lookup import mue_pkg::*; (
  input  logic [7:0] char_code,
  output seq_t       seq
);

  logic [7:0] folded;
  pat_t       pat;

  always_comb begin
    folded = char_code;
    if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
      folded = char_code | CASE_BIT;
    end
    if (folded >= CH_LOWER_A && folded <= CH_LOWER_Z) begin
      pat = letter_pattern(5'(folded - CH_LOWER_A));
    end else if (folded >= CH_ZERO && folded <= CH_NINE) begin
      pat = digit_pattern(4'(folded - CH_ZERO));
    end else if (folded == CH_SPACE) begin
      // word space: three off units ahead of the usual gap
      pat = mk_pat(CNT_W'(GAP_UNITS), PAT_W'(0));
    end else begin
      pat = mk_pat(CNT_W'(0), PAT_W'(0));
    end
    seq.total = pat.len + CNT_W'(GAP_UNITS);
    seq.units = {pat.bits, GAP_UNITS'(0)};
  end

endmodule

### hdl/mue_serializer.sv
// Unit sequencer: holds one character's units and sends them one per cycle while advance is high.
module mue_serializer import mue_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  seq_t seq,
  input  logic final_char,
  input  logic advance,
  output logic busy,
  output logic key_on,
  output logic char_done,
  output logic text_done
);

  logic [UNIT_W-1:0] units;
  logic [CNT_W-1:0]  cnt;
  logic              last_text;
  logic [CNT_W-1:0]  idx;

  assign busy      = (cnt != '0);
  assign idx       = cnt - CNT_W'(1);
  assign key_on    = units[idx];
  assign char_done = (cnt == CNT_W'(1));
  assign text_done = char_done & last_text;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= seq.total;
    end else if (advance) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // payload holds until the next character is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      units     <= seq.units;
      last_text <= final_char;
    end
  end

endmodule

### hdl/morse_unit_encoder.sv
// Top level of the Morse unit encoder: stream ports, lookup and unit sequencer.
// The first unit of a character is offered in the cycle after its request is taken.
// Units go out one per cycle while the output is ready; a character sends its pattern length
// plus 3 units (3 to 22), set by the unit down-counter; input is refused until the last unit
// goes, so no new request is taken while a character is still being sent.
// Reset (rst, synchronous, active high) clears the unit counter; the block comes up idle.
module morse_unit_encoder import mue_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // final_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] key_on, [7:1] zero
  output logic       m_tlast,   // char_done
  output logic       m_tuser    // text_done
);

  seq_t seq;
  logic busy;
  logic key_on;

  mue_lookup u_lookup (
    .char_code (s_tdata),
    .seq       (seq)
  );

  mue_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (s_tvalid & s_tready),
    .seq        (seq),
    .final_char (s_tlast),
    .advance    (m_tvalid & m_tready),
    .busy       (busy),
    .key_on     (key_on),
    .char_done  (m_tlast),
    .text_done  (m_tuser)
  );

  assign s_tready = ~busy;
  assign m_tvalid = busy;
  assign m_tdata  = {7'b0, key_on};

endmodule

### dv/morse_unit_encoder_tb.sv
`timescale 1ns / 100ps
// Testbench for the Morse unit encoder: queued character requests, predicted unit stream, checks.
module morse_unit_encoder_tb;
  import mue_pkg::*;

  localparam int RANDOM_CHARS = 230;
  localparam int TAIL_CHARS   = 30;    // last requests go with no idling on either side
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 120;
  localparam int SETTLE       = 2 * UNIT_W;
  localparam int STALL_LIMIT  = 5000;
  localparam int PRINT_CAP    = 20;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    logic       drain;   // wait for every unit of earlier requests first
  } char_req_t;

  typedef struct packed {
    logic key;
    logic char_end;
    logic text_end;
  } unit_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  char_req_t pending_chars[$];
  unit_t     expected_units[$];
  char_req_t cur_req;

  int tx_gap, rx_gap, rx_hold;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_done;
  int chars_taken, units_seen, texts_seen, errors, quiet_cycles;

  string letter_code[26] = '{
    "10111", "111010101", "11101011101", "1110101", "1",
    "101011101", "111011101", "1010101", "101", "1011101110111",
    "111010111", "101110101", "1110111", "11101", "11101110111",
    "10111011101", "1110111010111", "1011101", "10101", "111",
    "1010111", "101010111", "101110111", "11101010111", "1110101110111",
    "11101110101"
  };

  string digit_code[10] = '{
    "1110111011101110111", "10111011101110111", "101011101110111",
    "1010101110111", "10101010111", "101010101", "11101010101",
    "1110111010101", "111011101110101", "11101110111011101"
  };

  morse_unit_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Keying pattern of one character, without the trailing gap.
  function automatic string morse_of(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c | CASE_BIT;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return letter_code[c - CH_LOWER_A];
    if (c >= CH_ZERO && c <= CH_NINE) return digit_code[c - CH_ZERO];
    if (c == CH_SPACE) return "000";
    return "";
  endfunction

  task automatic queue_units(input char_req_t req);
    string pat;
    int    total;
    unit_t u;
    pat   = morse_of(req.code);
    total = pat.len() + GAP_UNITS;
    for (int k = 0; k < total; k++) begin
      u.key      = (k < pat.len()) && (pat[k] == "1");
      u.char_end = (k == total - 1);
      u.text_end = u.char_end && req.fin;
      expected_units.push_back(u);
    end
  endtask

  task automatic add_char(input logic [7:0] code, input logic fin, input logic drain);
    char_req_t req;
    req.code  = code;
    req.fin   = fin;
    req.drain = drain;
    pending_chars.push_back(req);
  endtask

  // Driver: predict on acceptance, hold a request until taken, then pick the next one.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        queue_units(cur_req);
        chars_taken++;
      end
      offer = 1'b0;
      if (s_tvalid && !s_tready) begin
        offer = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_chars.size() > 0 &&
                   (!pending_chars[0].drain || expected_units.size() == 0)) begin
        if (tx_idle_on && pending_chars.size() > TAIL_CHARS && $urandom_range(0, 4) == 0) begin
          tx_gap = $urandom_range(0, 13);
        end else begin
          cur_req = pending_chars.pop_front();
          s_tdata <= cur_req.code;
          s_tlast <= cur_req.fin;
          offer = 1'b1;
        end
      end
      s_tvalid <= offer;
      if ($urandom_range(0, 39) == 0) tx_idle_on = $urandom_range(0, 1);
    end
  end

  // Monitor: compare each taken unit with the oldest prediction, then drive ready.
  always @(posedge clk) begin
    unit_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap  = 0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.key      = m_tdata[0];
        got.char_end = m_tlast;
        got.text_end = m_tuser;
        units_seen++;
        if (got.text_end) texts_seen++;
        if (expected_units.size() == 0) begin
          errors++;
          if (errors <= PRINT_CAP)
            $display("%0t: unit with none expected: key_on %0b char_done %0b text_done %0b",
                     $time, got.key, got.char_end, got.text_end);
        end else begin
          want = expected_units.pop_front();
          if (got.key !== want.key || got.char_end !== want.char_end ||
              got.text_end !== want.text_end || m_tdata[7:1] !== 7'd0) begin
            errors++;
            if (errors <= PRINT_CAP) begin
              if (got.key !== want.key)
                $display("%0t: key_on expected %0b, got %0b", $time, want.key, got.key);
              if (got.char_end !== want.char_end)
                $display("%0t: char_done expected %0b, got %0b",
                         $time, want.char_end, got.char_end);
              if (got.text_end !== want.text_end)
                $display("%0t: text_done expected %0b, got %0b",
                         $time, want.text_end, got.text_end);
              if (m_tdata[7:1] !== 7'd0)
                $display("%0t: tdata padding expected 0, got %h", $time, m_tdata[7:1]);
            end
          end
        end
      end
      // Hold off once for a long stretch so the encoder backs up into its input.
      if (!hold_done && chars_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rx_hold   = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (rx_idle_on && pending_chars.size() > TAIL_CHARS &&
                   $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_idle_on = $urandom_range(0, 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no request or unit moved for %0d cycles", $time, STALL_LIMIT);
    $display("** morse_unit_encoder: FAILED **");
    $finish;
  end

  initial begin
    char_req_t req;

    // Field extremes, case folding, range edges just outside each class, space, final flag.
    add_char(CH_UPPER_A,     1'b0, 1'b0);
    add_char(CH_UPPER_Z,     1'b0, 1'b0);
    add_char(CH_LOWER_A,     1'b0, 1'b0);
    add_char(CH_LOWER_Z,     1'b1, 1'b0);
    add_char(CH_ZERO,        1'b0, 1'b0);
    add_char(CH_NINE,        1'b0, 1'b0);
    add_char(CH_SPACE,       1'b0, 1'b0);
    add_char(CH_SPACE,       1'b1, 1'b0);
    add_char(8'h00,          1'b0, 1'b0);
    add_char(8'hFF,          1'b1, 1'b0);
    add_char(8'h80,          1'b0, 1'b0);
    add_char(8'h7F,          1'b0, 1'b0);
    add_char(CH_UPPER_A - 8'd1,  1'b0, 1'b0);
    add_char(CH_UPPER_Z + 8'd1,  1'b0, 1'b0);
    add_char(CH_LOWER_A - 8'd1,  1'b1, 1'b0);
    add_char(CH_LOWER_Z + 8'd1,  1'b0, 1'b0);
    add_char(CH_ZERO - 8'd1,     1'b0, 1'b0);
    add_char(CH_NINE + 8'd1,     1'b0, 1'b0);
    add_char(CH_LOWER_A + 8'd4,  1'b0, 1'b0);
    add_char(CH_LOWER_A + 8'd19, 1'b0, 1'b0);
    add_char(CH_ZERO,        1'b1, 1'b0);

    // Mostly real text, some arbitrary bytes; two requests wait for a full drain.
    for (int i = 0; i < RANDOM_CHARS; i++) begin
      req.drain = (i == 60 || i == 150);
      req.fin   = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: req.code = CH_LOWER_A + 8'($urandom_range(0, 25));
        3, 4:    req.code = CH_UPPER_A + 8'($urandom_range(0, 25));
        5, 6:    req.code = CH_ZERO + 8'($urandom_range(0, 9));
        7:       req.code = CH_SPACE;
        default: req.code = 8'($urandom_range(0, 255));
      endcase
      pending_chars.push_back(req);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_units.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d characters (letters, digits, spaces, unmapped bytes) under random stalls,",
             chars_taken);
    $display("checked %0d key units including %0d end-of-text marks.", units_seen, texts_seen);
    if (errors == 0) begin
      $display("** morse_unit_encoder: PASSED **");
    end else begin
      $display("** morse_unit_encoder: FAILED **");
    end
    $finish;
  end

endmodule
